// ----- rtl/zssc_pkg.sv -----
`timescale 1ns / 1ps
// zssc_pkg: shared types, widths and codes for the zone step steering commander
// used by zssc_front, zssc_queue, zssc_back and the top level
package zssc_pkg;

   localparam int X_W     = 16;
   localparam int DUTY_W  = 8;
   localparam int TICKS_W = 21;
   localparam int DIR_W   = 2;
   localparam int BAL_W   = 8;
   localparam int CMD_W   = 32;
   localparam int BAL_CAP = 255;

   localparam int MAX_BALANCE_DEFAULT = 255;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [DUTY_W-1:0]  DUTY_RESET  = 8'd80;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 21'd78125;

   // register indexes
   localparam logic CSR_PULSE_DUTY  = 1'b0;
   localparam logic CSR_PULSE_TICKS = 1'b1;

   // steer directions
   localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;

   // signed zone as sign and magnitude, magnitude 0 is the centre zone
   typedef struct packed {
      logic       neg;
      logic [2:0] mag;
   } zone_type;

   typedef struct packed {
      logic     valid;
      zone_type zone;
   } queue_head_type;

endpackage

// ----- rtl/zssc_front.sv -----
`timescale 1ns / 1ps
// zssc_front: accepts position words and quantizes them into steering zones
// depends on zssc_pkg
module zssc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [zssc_pkg::X_W-1:0]      req_x_center,
   input  logic                          queue_full,
   output logic                          push_valid,
   output zssc_pkg::zone_type            push_zone
);

   localparam logic [zssc_pkg::X_W-1:0] DEAD_LO  = 16'd32441;
   localparam logic [zssc_pkg::X_W-1:0] DEAD_HI  = 16'd33095;
   localparam logic [zssc_pkg::X_W-1:0] LEFT_4   = 16'd8192;
   localparam logic [zssc_pkg::X_W-1:0] LEFT_3   = 16'd16384;
   localparam logic [zssc_pkg::X_W-1:0] LEFT_2   = 16'd24576;
   localparam logic [zssc_pkg::X_W-1:0] RIGHT_1  = 16'd40960;
   localparam logic [zssc_pkg::X_W-1:0] RIGHT_2  = 16'd49152;
   localparam logic [zssc_pkg::X_W-1:0] RIGHT_3  = 16'd57344;

   logic               hold_valid_ff;
   logic               hold_valid_in;
   zssc_pkg::zone_type zone_ff;
   zssc_pkg::zone_type zone_in;
   zssc_pkg::zone_type zone_now;
   logic               take;

   always_comb begin
      priority if (req_x_center >= DEAD_LO && req_x_center <= DEAD_HI) begin
         zone_now = '{neg: 1'b0, mag: 3'd0};
      end else if (req_x_center < LEFT_4) begin
         zone_now = '{neg: 1'b1, mag: 3'd4};
      end else if (req_x_center < LEFT_3) begin
         zone_now = '{neg: 1'b1, mag: 3'd3};
      end else if (req_x_center < LEFT_2) begin
         zone_now = '{neg: 1'b1, mag: 3'd2};
      end else if (req_x_center < DEAD_LO) begin
         zone_now = '{neg: 1'b1, mag: 3'd1};
      end else if (req_x_center <= RIGHT_1) begin
         zone_now = '{neg: 1'b0, mag: 3'd1};
      end else if (req_x_center <= RIGHT_2) begin
         zone_now = '{neg: 1'b0, mag: 3'd2};
      end else if (req_x_center <= RIGHT_3) begin
         zone_now = '{neg: 1'b0, mag: 3'd3};
      end else begin
         zone_now = '{neg: 1'b0, mag: 3'd4};
      end
   end

   assign req_stall  = hold_valid_ff & queue_full;
   assign take       = req_valid & ~req_stall;
   assign push_valid = hold_valid_ff & ~queue_full;
   assign push_zone  = zone_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      zone_in       = zone_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         zone_in       = zone_now;
      end else if (push_valid) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      zone_ff <= zone_in;
   end

endmodule

// ----- rtl/zssc_queue.sv -----
`timescale 1ns / 1ps
// zssc_queue: short zone queue between the classifier and the state update
// depends on zssc_pkg
module zssc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  zssc_pkg::zone_type      push_zone,
   output logic                    queue_full,
   input  logic                    pop,
   output zssc_pkg::queue_head_type head
);

   localparam int DEPTH = zssc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   zssc_pkg::zone_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign queue_full = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.zone  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & ~queue_full;
   assign do_pop     = pop & head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_zone;
      end
   end

endmodule

// ----- rtl/zssc_back.sv -----
`timescale 1ns / 1ps
// zssc_back: pulse balance state, return mode, config registers and output register
// depends on zssc_pkg
module zssc_back #(
   parameter int MAX_BALANCE = zssc_pkg::MAX_BALANCE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  zssc_pkg::queue_head_type          head,
   output logic                              pop,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [zssc_pkg::TICKS_W-1:0]      csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [zssc_pkg::CMD_W-1:0]        rsp_command_word,
   output logic [zssc_pkg::DIR_W-1:0]        rsp_steer_direction,
   output logic [zssc_pkg::BAL_W-1:0]        rsp_remaining_pulses
);

   localparam logic [zssc_pkg::BAL_W-1:0] LIMIT =
      (MAX_BALANCE > zssc_pkg::BAL_CAP) ? zssc_pkg::BAL_W'(zssc_pkg::BAL_CAP)
                                        : zssc_pkg::BAL_W'(MAX_BALANCE);

   logic [zssc_pkg::DUTY_W-1:0]  duty_ff;
   logic [zssc_pkg::TICKS_W-1:0] ticks_ff;

   logic [zssc_pkg::BAL_W-1:0]   bal_ff;
   logic [zssc_pkg::BAL_W-1:0]   bal_in;
   logic                         returning_ff;
   logic                         returning_in;
   logic [zssc_pkg::DIR_W-1:0]   pulse_dir_ff;
   logic [zssc_pkg::DIR_W-1:0]   pulse_dir_in;
   logic [2:0]                   held_mag_ff;
   logic [2:0]                   held_mag_in;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [zssc_pkg::CMD_W-1:0]   cmd_ff;
   logic [zssc_pkg::CMD_W-1:0]   cmd_in;
   logic [zssc_pkg::DIR_W-1:0]   dir_ff;
   logic [zssc_pkg::BAL_W-1:0]   remain_ff;

   logic [zssc_pkg::DIR_W-1:0]   dir;
   logic [zssc_pkg::DIR_W-1:0]   back_dir;
   logic                         out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= zssc_pkg::DUTY_RESET;
         ticks_ff <= zssc_pkg::TICKS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            zssc_pkg::CSR_PULSE_DUTY:  duty_ff  <= csr_wdata[zssc_pkg::DUTY_W-1:0];
            zssc_pkg::CSR_PULSE_TICKS: ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = head.valid & out_free;

   always_comb begin
      unique case (pulse_dir_ff)
         zssc_pkg::DIR_RIGHT: back_dir = zssc_pkg::DIR_LEFT;
         zssc_pkg::DIR_LEFT:  back_dir = zssc_pkg::DIR_RIGHT;
         default:             back_dir = zssc_pkg::DIR_NONE;
      endcase
   end

   always_comb begin
      dir          = zssc_pkg::DIR_NONE;
      bal_in       = bal_ff;
      returning_in = returning_ff;
      pulse_dir_in = pulse_dir_ff;
      held_mag_in  = held_mag_ff;
      if (pop) begin
         if (!returning_ff) begin
            priority if (head.zone.mag != 3'd0 && head.zone.mag > held_mag_ff) begin
               held_mag_in = head.zone.mag;
               if (bal_ff < LIMIT) begin
                  dir          = head.zone.neg ? zssc_pkg::DIR_LEFT : zssc_pkg::DIR_RIGHT;
                  bal_in       = bal_ff + 1'b1;
                  pulse_dir_in = dir;
               end
            end else if (head.zone.mag == 3'd0 && bal_ff != '0) begin
               returning_in = 1'b1;
            end else if (head.zone.mag != 3'd0 && head.zone.mag < held_mag_ff) begin
               held_mag_in = head.zone.mag;
            end else begin
            end
         end else begin
            if (bal_ff != '0 && back_dir != zssc_pkg::DIR_NONE) begin
               dir    = back_dir;
               bal_in = bal_ff - 1'b1;
            end else begin
               returning_in = 1'b0;
               held_mag_in  = 3'd0;
            end
         end
      end
   end

   assign cmd_in = {1'b1, dir, duty_ff, ticks_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = pop & (dir != zssc_pkg::DIR_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff       <= '0;
         returning_ff <= 1'b0;
         pulse_dir_ff <= zssc_pkg::DIR_NONE;
         held_mag_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bal_ff       <= bal_in;
         returning_ff <= returning_in;
         pulse_dir_ff <= pulse_dir_in;
         held_mag_ff  <= held_mag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_free) begin
         cmd_ff    <= cmd_in;
         dir_ff    <= dir;
         remain_ff <= bal_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_command_word     = cmd_ff;
   assign rsp_steer_direction  = dir_ff;
   assign rsp_remaining_pulses = remain_ff;

`ifndef SYNTHESIS
   a_bal_limit: assert property (@(posedge clock) disable iff (reset)
      bal_ff <= LIMIT)
      else $error("pulse balance above limit");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dir_ff == zssc_pkg::DIR_RIGHT || dir_ff == zssc_pkg::DIR_LEFT))
      else $error("result word without a steer direction");

   a_word_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cmd_ff[30:29] == dir_ff && cmd_ff[31]))
      else $error("command word direction disagrees with steer direction");

   a_remain: assert property (@(posedge clock) disable iff (reset)
      (out_free && pop && dir != zssc_pkg::DIR_NONE) |=> (remain_ff == bal_ff))
      else $error("remaining pulses differ from the balance");

   a_return_step: assert property (@(posedge clock) disable iff (reset)
      (pop && returning_ff && dir != zssc_pkg::DIR_NONE) |=> bal_ff == $past(bal_ff) - 1'b1)
      else $error("return pulse did not lower the balance");
`endif

endmodule

// ----- rtl/zone_step_steering_commander.sv -----
`timescale 1ns / 1ps
// zone_step_steering_commander: top level, classifier, zone queue and state update
// depends on zssc_pkg, zssc_front, zssc_queue, zssc_back
//
// Takes one lane-centre position word per cycle while req_stall is low and, for some of
// them, emits a steer command word. Sustained rate is one word per cycle while rsp_stall
// is low. A word is classified into a register at the edge that accepts it, then goes to
// one zone queue entry and the output register. The pulse balance update closes through
// one register in the back end, so words never wait on it. A stalled result holds the
// back end; the classifier register and the two queue entries take up to three more words
// before req_stall rises. Config registers are always ready and are sampled as each
// command is formed in the back end, so write them only while no word is in flight.
module zone_step_steering_commander #(
   parameter int MAX_BALANCE = zssc_pkg::MAX_BALANCE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [zssc_pkg::X_W-1:0]         req_x_center,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [zssc_pkg::CMD_W-1:0]       rsp_command_word,
   output logic [zssc_pkg::DIR_W-1:0]       rsp_steer_direction,
   output logic [zssc_pkg::BAL_W-1:0]       rsp_remaining_pulses,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [zssc_pkg::TICKS_W-1:0]     csr_wdata
);

   logic                     queue_full;
   logic                     push_valid;
   zssc_pkg::zone_type       push_zone;
   logic                     pop;
   zssc_pkg::queue_head_type head;

   zssc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_center (req_x_center),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_zone    (push_zone)
   );

   zssc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_zone  (push_zone),
      .queue_full (queue_full),
      .pop        (pop),
      .head       (head)
   );

   zssc_back #(
      .MAX_BALANCE (MAX_BALANCE)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_command_word     (rsp_command_word),
      .rsp_steer_direction  (rsp_steer_direction),
      .rsp_remaining_pulses (rsp_remaining_pulses)
   );

endmodule
